// File: hdl/ifsc_pkg.sv
package ifsc_pkg;
   localparam logic [15:0] FORMAT_IBM = 16'd1;
   localparam logic [31:0] FLT_MAX_BITS = 32'h7F7F_FFFF;
   localparam logic [31:0] FLT_NEG_MAX_BITS = 32'hFF7F_FFFF;
   localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
   localparam logic [30:0] INF_MAG = 31'h7F80_0000;

   // true when a < b under IEEE compare; NaN never less, +0 == -0
   function automatic logic ieee_less(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] ka;
      logic [31:0] kb;
      logic        res;
      ka = a[31] ? ~a : (a | SIGN_BIT);
      kb = b[31] ? ~b : (b | SIGN_BIT);
      res = ka < kb;
      if (a[30:0] > INF_MAG || b[30:0] > INF_MAG) res = 1'b0;
      if (a[30:0] == 31'd0 && b[30:0] == 31'd0) res = 1'b0;
      return res;
   endfunction
endpackage

// File: hdl/ifsc_convert.sv
module ifsc_convert (
   input  logic [31:0] word_in,
   input  logic        ibm_mode,
   output logic [31:0] value_out
);
   import ifsc_pkg::*;

   logic [23:0] frac;
   logic [6:0]  iexp;
   logic [4:0]  lz;
   logic [23:0] norm;
   logic signed [10:0] e;
   logic [31:0] conv;

   assign frac = word_in[23:0];
   assign iexp = word_in[30:24];

   // count leading zeros of the fraction
   always_comb begin
      lz = 5'd0;
      for (int i = 0; i < 24; i++) begin
         if (frac[i]) lz = 5'(23 - i);
      end
   end

   assign norm = frac << lz;
   assign e = $signed({2'b00, iexp, 2'b00}) - 11'sd130 - $signed({6'd0, lz});

   // build the IEEE pattern
   always_comb begin
      if (frac == 24'd0) begin
         conv = (iexp == 7'd127) ? {word_in[31], INF_MAG} : {word_in[31], 31'd0};
      end else if (e <= 11'sd0) begin
         conv = {word_in[31], 31'd0};
      end else if (e >= 11'sd255) begin
         conv = {word_in[31], INF_MAG};
      end else begin
         conv = {word_in[31], e[7:0], norm[22:0]};
      end
   end

   assign value_out = ibm_mode ? conv : word_in;
endmodule

// File: hdl/ibm_float_sample_converter_minmax_unit.sv
// Channel | Dir | tdata fields (low bit up)
// req     | in  | sample_word[31:0]; tuser = first_of_set
// rsp     | out | ieee_value[31:0], running_min[63:32], running_max[95:64]
// csr     | in  | sample_format[15:0]
// One beat per cycle unless rsp stalls; each result shows in the cycle after its
// request is taken, from the single result register after convert and min/max.
// Reset is synchronous: format 1, min/max to largest/most negative finite.
// A stalled output holds; the input is taken while the result moves on.
module ibm_float_sample_converter_minmax_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // sample_word
   input  logic        req_tuser,   // first_of_set
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // ieee_value, running_min, running_max
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);
   import ifsc_pkg::*;

   logic [15:0] format_ff;
   logic [31:0] min_ff, max_ff, min_in, max_in, base_min, base_max, val;
   logic        valid_ff, take;
   logic [95:0] data_ff;

   assign req_tready = !valid_ff || rsp_tready;
   assign take = req_tvalid && req_tready;

   ifsc_convert u_conv (.word_in(req_tdata), .ibm_mode(format_ff == FORMAT_IBM),
                        .value_out(val));

   // fold the sample into min and max
   always_comb begin
      base_min = req_tuser ? FLT_MAX_BITS : min_ff;
      base_max = req_tuser ? FLT_NEG_MAX_BITS : max_ff;
      min_in = ieee_less(val, base_min) ? val : base_min;
      max_in = ieee_less(base_max, val) ? val : base_max;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= FORMAT_IBM;
         min_ff <= FLT_MAX_BITS;
         max_ff <= FLT_NEG_MAX_BITS;
         valid_ff <= 1'b0;
      end else begin
         if (csr_we) format_ff <= csr_wdata;
         if (take) begin
            min_ff <= min_in;
            max_ff <= max_in;
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // hold the result beat
   always_ff @(posedge clock) begin
      if (take) data_ff <= {max_in, min_in, val};
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = data_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped under stall");
   a_valid: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_tvalid)
      else $error("accepted beat produced no result");
   a_state: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_tdata[63:32] == min_ff && rsp_tdata[95:64] == max_ff)
      else $error("state mismatch");
endmodule
